>>> rtl/psb_pkg.sv
`default_nettype none

package psb_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int COORD_W     = 13;
    localparam int SIZE_W      = 13;
    localparam int COUNT_W     = 12;
    localparam int PIXEL_W     = 8;
    localparam int MODE_W      = 2;
    localparam int ADDR_W      = 16;
    localparam int PLANE_W     = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SPRITE_WIDTH  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPRITE_HEIGHT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_COLOR     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BLIT_MODE     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_PAGE_BASE     = 3'd6;

    localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_KEYED = 2'd1;
    localparam logic [MODE_W-1:0] MODE_GET   = 2'd2;

    localparam logic [SIZE_W-1:0]  SIZE_MAX        = 13'd4096;
    localparam logic [PIXEL_W-1:0] KEY_COLOR_RESET = 8'h80;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic [SIZE_W-1:0]         sprite_width;
        logic [SIZE_W-1:0]         sprite_height;
        logic [PIXEL_W-1:0]        key_color;
        logic [MODE_W-1:0]         blit_mode;
        logic [ADDR_W-1:0]         page_base;
    } cfg_t;

    typedef struct packed {
        logic [COUNT_W-1:0] column;
        logic [COUNT_W-1:0] row;
    } count_t;

    typedef struct packed {
        logic               access_valid;
        logic               is_read;
        logic [PLANE_W-1:0] plane;
        logic [ADDR_W-1:0]  byte_address;
        logic [PIXEL_W-1:0] write_data;
        logic               last;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/psb_addr_calc.sv
`default_nettype none

module psb_addr_calc #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 200
) (
    input  wire psb_pkg::cfg_t    cfg,
    input  wire psb_pkg::count_t  count,
    input  wire [7:0]             pixel,
    output psb_pkg::result_t      result,
    output psb_pkg::count_t       count_next
);
    import psb_pkg::*;

    localparam int ROW_BYTES = SCREEN_WIDTH / 4;

    logic [SIZE_W-1:0]         w_eff;
    logic [SIZE_W-1:0]         h_eff;
    logic [SIZE_W-1:0]         w_m1;
    logic [SIZE_W-1:0]         h_m1;
    logic                      row_end;
    logic                      last;
    logic signed [COORD_W:0]   col;
    logic signed [COORD_W:0]   row;
    logic                      visible;
    logic                      hit;
    logic                      rd;
    logic [ADDR_W-1:0]         row_off;
    logic [ADDR_W-1:0]         row_u;

    always_comb
    begin
        w_eff = (cfg.sprite_width == '0) ? SIZE_W'(1)
              : ((cfg.sprite_width > SIZE_MAX) ? SIZE_MAX : cfg.sprite_width);
        h_eff = (cfg.sprite_height == '0) ? SIZE_W'(1)
              : ((cfg.sprite_height > SIZE_MAX) ? SIZE_MAX : cfg.sprite_height);
        w_m1 = w_eff - SIZE_W'(1);
        h_m1 = h_eff - SIZE_W'(1);

        row_end = count.column >= w_m1[COUNT_W-1:0];
        last    = row_end && (count.row >= h_m1[COUNT_W-1:0]);

        col = {cfg.origin_x[COORD_W-1], cfg.origin_x} + $signed({2'b00, count.column});
        row = {cfg.origin_y[COORD_W-1], cfg.origin_y} + $signed({2'b00, count.row});

        visible = !col[COORD_W] && (col[COORD_W-1:0] < COORD_W'(SCREEN_WIDTH))
               && !row[COORD_W] && (row[COORD_W-1:0] < COORD_W'(SCREEN_HEIGHT));

        hit = 1'b0;
        rd  = 1'b0;
        case (cfg.blit_mode)
            MODE_PUT:
            begin
                hit = 1'b1;
            end
            MODE_KEYED:
            begin
                hit = pixel != cfg.key_color;
            end
            MODE_GET:
            begin
                hit = 1'b1;
                rd  = 1'b1;
            end
            default:
            begin
                hit = 1'b0;
            end
        endcase

        row_u   = {{(ADDR_W-COORD_W){1'b0}}, row[COORD_W-1:0]};
        row_off = ADDR_W'(row_u * ADDR_W'(ROW_BYTES));

        result = '0;
        result.last = last;
        if (visible && hit)
        begin
            result.access_valid = 1'b1;
            result.is_read      = rd;
            result.plane        = col[PLANE_W-1:0];
            result.byte_address = cfg.page_base + row_off
                                + {{(ADDR_W-COORD_W+2){1'b0}}, col[COORD_W-1:2]};
            result.write_data   = rd ? '0 : pixel;
        end

        if (last)
        begin
            count_next = '0;
        end
        else if (row_end)
        begin
            count_next.column = '0;
            count_next.row    = count.row + COUNT_W'(1);
        end
        else
        begin
            count_next.column = count.column + COUNT_W'(1);
            count_next.row    = count.row;
        end
    end

endmodule

`default_nettype wire

>>> rtl/psb_skid.sv
`default_nettype none

module psb_skid (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    up_valid,
    output logic                   up_stall,
    input  wire psb_pkg::result_t  up_data,
    output logic                   dn_valid,
    input  wire                    dn_stall,
    output psb_pkg::result_t       dn_data
);
    import psb_pkg::*;

    logic    out_valid_reg;
    logic    out_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t out_data_reg;
    result_t out_data_next;
    result_t skid_data_reg;
    result_t skid_data_next;
    logic    accept;

    assign up_stall = skid_valid_reg;
    assign accept   = up_valid && !skid_valid_reg;
    assign dn_valid = out_valid_reg;
    assign dn_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || !dn_stall)
        begin
            out_valid_next  = skid_valid_reg || accept;
            out_data_next   = skid_valid_reg ? skid_data_reg : up_data;
            skid_valid_next = 1'b0;
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = up_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire

>>> rtl/planar_sprite_blit_address_gen_core.sv
`default_nettype none

// channel   handshake               payload
// config    wr_en                   wr_index[2:0], wr_data[15:0]
// pixel     pix_valid / pix_stall   pixel[7:0]
// access    acc_valid / acc_stall   access_valid, is_read, plane, byte_address,
//                                   write_data, last
//
// one pixel beat per cycle while not stalled; its access beat is registered
// the address math sits between the counter registers and the output register
// a two-deep output stage lets one more pixel in while acc_stall is high
// rst_n clears counters and config to their defaults; no clearing pass
// any config write restarts the counters at the sprite's top left

module planar_sprite_blit_address_gen_core #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 200
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         wr_en,
    input  wire  [2:0]  wr_index,
    input  wire  [15:0] wr_data,
    input  wire         pix_valid,
    output logic        pix_stall,
    input  wire  [7:0]  pixel,
    output logic        acc_valid,
    input  wire         acc_stall,
    output logic        access_valid,
    output logic        is_read,
    output logic [1:0]  plane,
    output logic [15:0] byte_address,
    output logic [7:0]  write_data,
    output logic        last
);
    import psb_pkg::*;

    cfg_t    cfg_reg;
    count_t  count_reg;
    count_t  count_next;
    result_t calc_result;
    result_t acc_data;
    logic    pix_take;

    assign pix_take = pix_valid && !pix_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x      <= '0;
            cfg_reg.origin_y      <= '0;
            cfg_reg.sprite_width  <= SIZE_W'(1);
            cfg_reg.sprite_height <= SIZE_W'(1);
            cfg_reg.key_color     <= KEY_COLOR_RESET;
            cfg_reg.blit_mode     <= MODE_PUT;
            cfg_reg.page_base     <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_ORIGIN_X:      cfg_reg.origin_x      <= $signed(wr_data[COORD_W-1:0]);
                REG_ORIGIN_Y:      cfg_reg.origin_y      <= $signed(wr_data[COORD_W-1:0]);
                REG_SPRITE_WIDTH:  cfg_reg.sprite_width  <= wr_data[SIZE_W-1:0];
                REG_SPRITE_HEIGHT: cfg_reg.sprite_height <= wr_data[SIZE_W-1:0];
                REG_KEY_COLOR:     cfg_reg.key_color     <= wr_data[PIXEL_W-1:0];
                REG_BLIT_MODE:     cfg_reg.blit_mode     <= wr_data[MODE_W-1:0];
                REG_PAGE_BASE:     cfg_reg.page_base     <= wr_data[ADDR_W-1:0];
                default:           cfg_reg.page_base     <= cfg_reg.page_base;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (wr_en)
        begin
            count_reg <= '0;
        end
        else if (pix_take)
        begin
            count_reg <= count_next;
        end
    end

    psb_addr_calc #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_calc (
        .cfg        (cfg_reg),
        .count      (count_reg),
        .pixel      (pixel),
        .result     (calc_result),
        .count_next (count_next)
    );

    psb_skid u_skid (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (pix_valid),
        .up_stall (pix_stall),
        .up_data  (calc_result),
        .dn_valid (acc_valid),
        .dn_stall (acc_stall),
        .dn_data  (acc_data)
    );

    assign access_valid = acc_data.access_valid;
    assign is_read      = acc_data.is_read;
    assign plane        = acc_data.plane;
    assign byte_address = acc_data.byte_address;
    assign write_data   = acc_data.write_data;
    assign last         = acc_data.last;

endmodule

`default_nettype wire
